### src/assert_macros.svh
// Assertion macros used by the converter checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### src/f2h_pkg.sv
// Constants for the fp32 to fp20 converter
`default_nettype none
package f2h_pkg;
   localparam int unsigned ExpLow     = 84;
   localparam int unsigned ExpHigh    = 159;
   localparam int unsigned ExpOffset  = 96;
   localparam int unsigned ExpNormal  = 97;
   localparam logic [5:0]  ExpMax     = 6'b111110;
   localparam logic [12:0] MantMax    = 13'b1111111111111;
   localparam logic [23:0] RoundAdd   = 24'b10000000000;
   typedef logic [19:0] word20_type;
endpackage
`default_nettype wire

### src/fp32_to_fp20_converter.sv
// fp32 to fp20 converter top level
//
// Usage:
//   Drive req_single_bits and raise start; the transaction is taken at
//   the rising edge where start is high and busy is low. busy is always low
//   out of reset, so one value can be taken every clock cycle.
//   The result appears on rsp_half20_bits, rsp_overflow_flag and
//   rsp_underflow_flag in the cycle after the input register loads, marked
//   by rsp_valid for one cycle.
//   Throughput: 1 transaction per cycle, set by the two-register path.
//   Reset clears both valid bits; no result is pending afterwards.
//   The receiver cannot stall; each result is shown for exactly one cycle.
//   Overflow saturates to exponent 62, mantissa all ones, sign kept.
//   Underflow gives +0.
`default_nettype none
module fp32_to_fp20_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_single_bits,
   output logic             rsp_valid,
   output logic [19:0]      rsp_half20_bits,
   output logic             rsp_overflow_flag,
   output logic             rsp_underflow_flag
);
   logic        in_vld_ff;
   logic [31:0] in_bits_ff;
   logic        out_vld_ff;
   logic [19:0] out_bits_ff, out_bits_in;
   logic        ovf_ff, ovf_in, unf_ff, unf_in;

   logic        sgn;
   logic [7:0]  e;
   logic [22:0] f;
   logic [23:0] full, shifted, rnd;
   logic [3:0]  sh;
   logic [19:0] mag;

   assign busy = 1'b0;

   always_comb begin
      sgn = in_bits_ff[31];
      e   = in_bits_ff[30:23];
      f   = in_bits_ff[22:0];
      full = {1'b1, f};
      sh  = 4'(8'(f2h_pkg::ExpNormal) - e);
      shifted = full >> sh;
      if (e >= 8'(f2h_pkg::ExpNormal)) begin
         rnd = {1'b0, f} + (f[9] ? f2h_pkg::RoundAdd : 24'd0);
         mag = {6'(e - 8'(f2h_pkg::ExpOffset)), 13'd0} + 20'(rnd[23:10]);
      end else begin
         rnd = shifted + (full[5'd9 + 5'(sh)] ? f2h_pkg::RoundAdd : 24'd0);
         mag = 20'(rnd[23:10]);
      end
      out_bits_in = {sgn, mag[18:0]};
      ovf_in = 1'b0;
      unf_in = 1'b0;
      if (e < 8'(f2h_pkg::ExpLow)) begin
         out_bits_in = '0;
         unf_in = 1'b1;
      end else if (e >= 8'(f2h_pkg::ExpHigh) || mag[19:13] > 7'(f2h_pkg::ExpMax)) begin
         out_bits_in = {sgn, f2h_pkg::ExpMax, f2h_pkg::MantMax};
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= start;
         out_vld_ff <= in_vld_ff;
      end
      in_bits_ff  <= req_single_bits;
      out_bits_ff <= out_bits_in;
      ovf_ff      <= ovf_in;
      unf_ff      <= unf_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_half20_bits    = out_bits_ff;
   assign rsp_overflow_flag  = ovf_ff;
   assign rsp_underflow_flag = unf_ff;
endmodule
`default_nettype wire

### src/f2h_checker.sv
// Port-level checker for the fp32 to fp20 converter
`default_nettype none
`include "assert_macros.svh"
module f2h_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [19:0] rsp_half20_bits,
   input wire logic        rsp_overflow_flag,
   input wire logic        rsp_underflow_flag
);
   logic        both_flags, ovf_rsp, unf_rsp;
   logic [18:0] sat_mag;

   assign both_flags = rsp_overflow_flag && rsp_underflow_flag;
   assign ovf_rsp    = rsp_valid && rsp_overflow_flag;
   assign unf_rsp    = rsp_valid && rsp_underflow_flag;
   assign sat_mag    = {f2h_pkg::ExpMax, f2h_pkg::MantMax};

   `ASSERT_IMPL(a_flags_excl, clock, reset, rsp_valid, !both_flags, "both flags set")
   `ASSERT_IMPL(a_unf_zero, clock, reset, unf_rsp, rsp_half20_bits == '0, "underflow not zero")
   `ASSERT_IMPL(a_ovf_sat, clock, reset, ovf_rsp, rsp_half20_bits[18:0] == sat_mag, "not saturated")
   `ASSERT_NEXT(a_lat, clock, reset, start && !busy, ##1 rsp_valid, "result missing")
endmodule
bind fp32_to_fp20_converter f2h_checker u_chk (.*);
`default_nettype wire
